### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons must hold at the same edge as ante
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/htw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package htw_pkg;

    typedef enum logic [1:0] {
        MODE_STRAIGHT = 2'd0,
        MODE_SOFT     = 2'd1,
        MODE_HARD     = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CFG_HARD_THR     = 2'd0,
        CFG_SOFT_THR     = 2'd1,
        CFG_STRAIGHT_THR = 2'd2,
        CFG_MAX_SPEED    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_MUL  = 2'd1,
        B_DIV  = 2'd2,
        B_DONE = 2'd3
    } back_state_t;

    localparam int ThrW   = 14;
    localparam int SpeedW = 16;
    localparam int AngW   = 15;
    localparam int OutW   = 18;

    localparam logic [ThrW-1:0]   HardThrRst     = 14'd6434;
    localparam logic [ThrW-1:0]   SoftThrRst     = 14'd5004;
    localparam logic [ThrW-1:0]   StraightThrRst = 14'd715;
    localparam logic [SpeedW-1:0] MaxSpeedRst    = 16'd2560;

    typedef struct packed {
        logic [ThrW-1:0]   hard_thr;
        logic [ThrW-1:0]   soft_thr;
        logic [ThrW-1:0]   straight_thr;
        logic [SpeedW-1:0] speed_cap;
    } cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        mode_t             mode;
        logic [SpeedW-1:0] base;
        logic [AngW-1:0]   mag;
        logic              pos;
    } entry_t;

endpackage

`default_nettype wire

### hdl/htw_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module htw_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr,
    input  wire htw_pkg::entry_t wdata,
    output logic                 full,
    input  wire logic            rd,
    output htw_pkg::entry_t      rdata,
    output logic                 empty
);

    htw_pkg::entry_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            do_wr;
    logic            do_rd;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `ASSERT_IMPL(a_ptrs_track_count, count_reg == 2'd0 || count_reg == 2'd2, wr_ptr_reg == rd_ptr_reg, "fifo pointers disagree with count")

endmodule

`default_nettype wire

### hdl/htw_front.sv
`timescale 1ns / 1ps
`default_nettype none

module htw_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire htw_pkg::cfg_t                      cfg,
    input  wire logic                               push,
    input  wire logic signed [htw_pkg::AngW-1:0]    heading_angle,
    input  wire logic        [htw_pkg::SpeedW-1:0]  heading_length,
    input  wire logic                               q_full,
    output logic                                    q_wr,
    output htw_pkg::entry_t                         q_data
);

    htw_pkg::mode_t            mode_reg;
    htw_pkg::mode_t            mode_next;
    htw_pkg::mode_t            m;
    logic [htw_pkg::AngW-1:0]  mag;
    logic [htw_pkg::AngW-1:0]  hard_x;
    logic [htw_pkg::AngW-1:0]  soft_x;
    logic [htw_pkg::AngW-1:0]  straight_x;
    logic [htw_pkg::SpeedW-1:0] base;

    assign q_wr       = push && !q_full;
    // -16384 negates to 0x4000, which reads correctly as unsigned
    assign mag        = heading_angle[htw_pkg::AngW-1] ? (~heading_angle + 1'b1)
                                                       : heading_angle;
    assign hard_x     = {1'b0, cfg.hard_thr};
    assign soft_x     = {1'b0, cfg.soft_thr};
    assign straight_x = {1'b0, cfg.straight_thr};
    assign base       = (heading_length < cfg.speed_cap) ? heading_length : cfg.speed_cap;

    // checks run hard -> soft -> straight, so one beat may cascade
    always_comb
    begin
        m = mode_reg;
        if (m == htw_pkg::MODE_HARD && mag <= soft_x)
        begin
            m = htw_pkg::MODE_SOFT;
        end
        if (m == htw_pkg::MODE_SOFT)
        begin
            if (mag > hard_x)
            begin
                m = htw_pkg::MODE_HARD;
            end
            else if (mag <= straight_x)
            begin
                m = htw_pkg::MODE_STRAIGHT;
            end
        end
        if (m == htw_pkg::MODE_STRAIGHT)
        begin
            if (mag > hard_x)
            begin
                m = htw_pkg::MODE_HARD;
            end
            else if (mag > straight_x)
            begin
                m = htw_pkg::MODE_SOFT;
            end
        end
        mode_next = q_wr ? m : mode_reg;
    end

    assign q_data.mode = m;
    assign q_data.base = base;
    assign q_data.mag  = mag;
    assign q_data.pos  = !heading_angle[htw_pkg::AngW-1] && (heading_angle != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= htw_pkg::MODE_STRAIGHT;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

`default_nettype wire

### hdl/htw_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module htw_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire htw_pkg::cfg_t                     cfg,
    input  wire logic                              q_empty,
    input  wire htw_pkg::entry_t                   q_data,
    output logic                                   q_rd,
    input  wire logic                              pop,
    output logic                                   out_valid,
    output logic signed [htw_pkg::OutW-1:0]        left_speed,
    output logic signed [htw_pkg::OutW-1:0]        right_speed,
    output logic        [1:0]                      turn_mode
);

    htw_pkg::back_state_t         state_reg;
    htw_pkg::back_state_t         state_next;
    htw_pkg::entry_t              entry_reg;
    logic [30:0]                  prod_reg;
    logic [htw_pkg::ThrW-1:0]     rem_reg;
    logic [htw_pkg::ThrW-1:0]     rem_next;
    logic [htw_pkg::SpeedW-1:0]   quot_reg;
    logic [1:0]                   step_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic signed [htw_pkg::OutW-1:0] left_reg;
    logic signed [htw_pkg::OutW-1:0] right_reg;
    logic [1:0]                   mode_out_reg;

    logic                         load;
    logic                         write_out;
    logic [htw_pkg::ThrW-1:0]     r;
    logic [htw_pkg::ThrW:0]       t;
    logic [3:0]                   dbits;
    logic [3:0]                   qbits;
    logic signed [htw_pkg::OutW-1:0] slow;
    logic signed [htw_pkg::OutW-1:0] fast;
    logic signed [htw_pkg::OutW-1:0] base_s;
    logic signed [htw_pkg::OutW-1:0] delta_s;
    logic signed [htw_pkg::OutW-1:0] max_s;

    // four restoring steps per cycle; high product half is already below the divisor
    always_comb
    begin
        r = (step_reg == 2'd0) ? prod_reg[29:16] : rem_reg;
        case (step_reg)
            2'd0:    dbits = prod_reg[15:12];
            2'd1:    dbits = prod_reg[11:8];
            2'd2:    dbits = prod_reg[7:4];
            default: dbits = prod_reg[3:0];
        endcase
        t     = '0;
        qbits = '0;
        for (int i = 3; i >= 0; i--)
        begin
            t = {r, dbits[i]};
            if (t >= {1'b0, cfg.hard_thr})
            begin
                t        = t - {1'b0, cfg.hard_thr};
                qbits[i] = 1'b1;
            end
            r = t[htw_pkg::ThrW-1:0];
        end
        rem_next = r;
    end

    always_comb
    begin
        base_s  = {2'b00, entry_reg.base};
        delta_s = {2'b00, quot_reg};
        max_s   = {2'b00, cfg.speed_cap};
        unique case (entry_reg.mode)
            htw_pkg::MODE_SOFT:
            begin
                slow = base_s - delta_s;
                fast = base_s + delta_s;
            end
            htw_pkg::MODE_HARD:
            begin
                slow = -max_s;
                fast = max_s;
            end
            default:
            begin
                slow = base_s;
                fast = base_s;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        load           = 1'b0;
        write_out      = 1'b0;
        out_valid_next = out_valid_reg && !pop;
        unique case (state_reg)
            htw_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    load = 1'b1;
                    if (q_data.mode == htw_pkg::MODE_SOFT && cfg.hard_thr != '0)
                    begin
                        state_next = htw_pkg::B_MUL;
                    end
                    else
                    begin
                        state_next = htw_pkg::B_DONE;
                    end
                end
            end
            htw_pkg::B_MUL:
            begin
                state_next = htw_pkg::B_DIV;
            end
            htw_pkg::B_DIV:
            begin
                if (step_reg == 2'd3)
                begin
                    state_next = htw_pkg::B_DONE;
                end
            end
            htw_pkg::B_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    write_out      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = htw_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = htw_pkg::B_IDLE;
            end
        endcase
    end

    assign q_rd        = load;
    assign out_valid   = out_valid_reg;
    assign left_speed  = left_reg;
    assign right_speed = right_reg;
    assign turn_mode   = mode_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= htw_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= (state_reg == htw_pkg::B_DIV) ? step_reg + 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= q_data;
            quot_reg  <= '0;
        end
        if (state_reg == htw_pkg::B_MUL)
        begin
            prod_reg <= entry_reg.base * entry_reg.mag;
        end
        if (state_reg == htw_pkg::B_DIV)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[11:0], qbits};
        end
        if (write_out)
        begin
            left_reg     <= entry_reg.pos ? slow : fast;
            right_reg    <= entry_reg.pos ? fast : slow;
            mode_out_reg <= entry_reg.mode;
        end
    end

    `ASSERT_IMPL(a_rem_below_divisor, state_reg == htw_pkg::B_DIV && step_reg != 2'd0, rem_reg < cfg.hard_thr, "partial remainder not below divisor")
    `ASSERT_IMPL(a_delta_within_base, state_reg == htw_pkg::B_DONE, quot_reg <= entry_reg.base, "soft delta exceeds base speed")

endmodule

`default_nettype wire

### hdl/hysteretic_turn_wheel_mixer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// The back-end sequencer takes one beat at a time: load, multiply, division in four
// radix-16 steps, result write. Straight/hard beats skip multiply and division, and the
// result write waits until the result register is free or is popped.
// A 2-entry queue and the result register let 3 more beats enter while a result waits.
// Reset (async, active low) clears the turn mode to straight, empties the queue and
// result register, and loads the threshold and max speed registers with their defaults.

module hysteretic_turn_wheel_mixer_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [1:0]                         cfg_index,
    input  wire logic [htw_pkg::SpeedW-1:0]         cfg_data,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic signed [htw_pkg::AngW-1:0]    heading_angle,
    input  wire logic        [htw_pkg::SpeedW-1:0]  heading_length,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic signed [htw_pkg::OutW-1:0]         left_speed,
    output logic signed [htw_pkg::OutW-1:0]         right_speed,
    output logic        [1:0]                       turn_mode
);

    htw_pkg::cfg_t   cfg_reg;
    htw_pkg::cfg_t   cfg_next;
    htw_pkg::entry_t wr_data;
    htw_pkg::entry_t rd_data;
    logic            q_wr;
    logic            q_rd;
    logic            q_full;
    logic            q_empty;
    logic            out_valid;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign empty     = !out_valid;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (htw_pkg::cfg_index_t'(cfg_index))
                htw_pkg::CFG_HARD_THR:     cfg_next.hard_thr     = cfg_data[htw_pkg::ThrW-1:0];
                htw_pkg::CFG_SOFT_THR:     cfg_next.soft_thr     = cfg_data[htw_pkg::ThrW-1:0];
                htw_pkg::CFG_STRAIGHT_THR: cfg_next.straight_thr = cfg_data[htw_pkg::ThrW-1:0];
                htw_pkg::CFG_MAX_SPEED:    cfg_next.speed_cap    = cfg_data;
                default:                   cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hard_thr     <= htw_pkg::HardThrRst;
            cfg_reg.soft_thr     <= htw_pkg::SoftThrRst;
            cfg_reg.straight_thr <= htw_pkg::StraightThrRst;
            cfg_reg.speed_cap    <= htw_pkg::MaxSpeedRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    htw_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .push           (push),
        .heading_angle  (heading_angle),
        .heading_length (heading_length),
        .q_full         (q_full),
        .q_wr           (q_wr),
        .q_data         (wr_data)
    );

    htw_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (wr_data),
        .full  (q_full),
        .rd    (q_rd),
        .rdata (rd_data),
        .empty (q_empty)
    );

    htw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .q_data      (rd_data),
        .q_rd        (q_rd),
        .pop         (pop),
        .out_valid   (out_valid),
        .left_speed  (left_speed),
        .right_speed (right_speed),
        .turn_mode   (turn_mode)
    );

endmodule

`default_nettype wire
